// File: rtl/core/utf8_stream_decoder_top_macros.svh
// assertion macros for the utf8 stream decoder
// expects clk_i and rst_ni in the scope of each use
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define USD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/usd_pkg.sv
// shared types, constants and helpers for the utf8 stream decoder
// no dependencies
package usd_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned KIND_W = 3;

  // smallest legal value per sequence length
  localparam logic [CP_W-1:0] MIN_LEN2 = 21'h00080;
  localparam logic [CP_W-1:0] MIN_LEN3 = 21'h00800;
  localparam logic [CP_W-1:0] MIN_LEN4 = 21'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR         = 3'd0,
    KIND_BAD_LEAD     = 3'd1,
    KIND_MISSING_CONT = 3'd2,
    KIND_OVERLONG     = 3'd3,
    KIND_TRUNCATED    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    kind_e           kind;
    logic            last;
  } result_t;

  // results produced by one byte, in order
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
    logic       idle;
  } dec_out_t;

  typedef struct packed {
    logic       push_ready;
    logic [1:0] occ;
  } q_stat_t;

  function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      3'd2:    v = MIN_LEN2;
      3'd3:    v = MIN_LEN3;
      3'd4:    v = MIN_LEN4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/usd_if.sv
// handshake channels of the utf8 stream decoder
// depends on usd_pkg
interface usd_byte_if import usd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface usd_result_if import usd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [KIND_W-1:0] kind;
  logic              last;

  modport source (output valid, output code_point, output kind, output last, input ready);
  modport sink   (input valid, input code_point, input kind, input last, output ready);
endinterface

// File: rtl/core/usd_decode.sv
// decoder state and per-byte decode logic
// depends on usd_pkg
module usd_decode import usd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  input  logic       advance_i,
  output dec_out_t   dec_o
);

  logic [CP_W-1:0] acc_q, acc_d;
  logic [1:0]      pend_q, pend_d;
  logic [2:0]      len_q, len_d;
  logic            skip_q, skip_d;

  logic            is_cont;
  logic            lead_emit;
  kind_e           lead_kind;
  logic [CP_W-1:0] lead_cp;
  logic [CP_W-1:0] lead_acc;
  logic [1:0]      lead_pend;
  logic [2:0]      lead_len;
  logic            lead_skip;

  logic            a_v, b_v, c_v, take_lead;
  kind_e           a_kind;
  logic [CP_W-1:0] a_cp;
  logic [CP_W-1:0] acc_shift;
  logic [1:0]      pend_dec;
  result_t         res_a, res_b, res_c;

  assign is_cont   = (data_byte_i[7:6] == 2'b10);
  assign acc_shift = {acc_q[CP_W-7:0], data_byte_i[5:0]};
  assign pend_dec  = pend_q - 2'd1;

  // lead byte classification
  always_comb begin
    lead_emit = 1'b0;
    lead_kind = KIND_CHAR;
    lead_cp   = '0;
    lead_acc  = '0;
    lead_pend = '0;
    lead_len  = '0;
    lead_skip = 1'b0;
    priority if (!data_byte_i[7]) begin
      lead_emit = 1'b1;
      lead_cp   = {{(CP_W-8){1'b0}}, data_byte_i};
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_acc  = {{(CP_W-5){1'b0}}, data_byte_i[4:0]};
      lead_pend = 2'd1;
      lead_len  = 3'd2;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_acc  = {{(CP_W-4){1'b0}}, data_byte_i[3:0]};
      lead_pend = 2'd2;
      lead_len  = 3'd3;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_acc  = {{(CP_W-3){1'b0}}, data_byte_i[2:0]};
      lead_pend = 2'd3;
      lead_len  = 3'd4;
    end else begin
      lead_emit = 1'b1;
      lead_kind = KIND_BAD_LEAD;
      lead_skip = 1'b1;
    end
  end

  always_comb begin
    acc_d     = acc_q;
    pend_d    = pend_q;
    len_d     = len_q;
    skip_d    = skip_q;
    a_v       = 1'b0;
    a_kind    = KIND_CHAR;
    a_cp      = '0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    take_lead = 1'b0;

    if (pend_q != 2'd0) begin
      if (is_cont) begin
        if (pend_dec == 2'd0) begin
          a_v = 1'b1;
          if (acc_shift < min_value(len_q)) begin
            a_kind = KIND_OVERLONG;
            skip_d = 1'b1;
          end else begin
            a_cp = acc_shift;
          end
          acc_d  = '0;
          pend_d = '0;
          len_d  = '0;
        end else begin
          acc_d  = acc_shift;
          pend_d = pend_dec;
        end
      end else begin
        a_v       = 1'b1;
        a_kind    = KIND_MISSING_CONT;
        take_lead = 1'b1;
      end
    end else if (!(skip_q && is_cont)) begin
      take_lead = 1'b1;
    end

    if (take_lead) begin
      b_v    = lead_emit;
      skip_d = lead_skip;
      acc_d  = lead_acc;
      pend_d = lead_pend;
      len_d  = lead_len;
    end

    if (end_of_text_i) begin
      c_v    = (pend_d != 2'd0);
      acc_d  = '0;
      pend_d = '0;
      len_d  = '0;
      skip_d = 1'b0;
    end
  end

  // order the results and mark the final one
  always_comb begin
    res_a = '{code_point: a_cp,    kind: a_kind,         last: 1'b0};
    res_b = '{code_point: lead_cp, kind: lead_kind,      last: 1'b0};
    res_c = '{code_point: '0,      kind: KIND_TRUNCATED, last: 1'b0};

    dec_o.n    = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
    dec_o.r0   = a_v ? res_a : (b_v ? res_b : res_c);
    dec_o.r1   = (a_v && b_v) ? res_b : res_c;
    dec_o.idle = (pend_q == 2'd0) && !skip_q && (acc_q == '0) && (len_q == '0);
    if (dec_o.n == 2'd1) begin
      dec_o.r0.last = 1'b1;
    end else begin
      dec_o.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      len_q  <= '0;
      skip_q <= 1'b0;
    end else if (advance_i) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: rtl/core/usd_outq.sv
// two-entry result queue, takes up to two results per cycle while it has room for them
// depends on usd_pkg
module usd_outq import usd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  dec_out_t dec_i,
  input  logic     pop_ready_i,
  output result_t  head_o,
  output logic     head_valid_o,
  output q_stat_t  stat_o
);

  result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] occ_q, occ_d;
  logic [1:0] occ_ap, space, n_eff;
  logic       pop, push;
  result_t    keep;

  assign pop    = (occ_q != 2'd0) && pop_ready_i;
  assign occ_ap = occ_q - {1'b0, pop};
  assign space  = 2'd2 - occ_ap;
  assign stat_o.push_ready = (dec_i.n <= space);
  assign stat_o.occ        = occ_q;
  assign push   = push_valid_i && stat_o.push_ready;
  assign n_eff  = push ? dec_i.n : 2'd0;
  assign keep   = pop ? slot1_q : slot0_q;
  assign occ_d  = occ_ap + n_eff;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    unique case (occ_ap)
      2'd0: begin
        slot0_d = dec_i.r0;
        slot1_d = dec_i.r1;
      end
      2'd1: begin
        slot0_d = keep;
        slot1_d = dec_i.r0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign head_o       = slot0_q;
  assign head_valid_o = (occ_q != 2'd0);

endmodule

// File: rtl/core/utf8_stream_decoder_top.sv
// path: a byte is registered in the input register, then its results in the result queue
// throughput: one byte per cycle while the queue has room for its results; a byte with
// two results can fill the two-entry queue, and later bytes wait for the single result port
// reset: asynchronous active-low, clears decoder state, input and queue valid
// depends on usd_pkg, usd_if, usd_decode, usd_outq and the macros header
`include "utf8_stream_decoder_top_macros.svh"

module utf8_stream_decoder_top import usd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  usd_byte_if.sink     byte_i,
  usd_result_if.source result_o
);

  // input register
  logic [7:0] byte_q;
  logic       eot_q;
  logic       valid_q;
  logic       advance;
  logic       in_accept;

  dec_out_t   dec;
  q_stat_t    q_stat;
  result_t    head;
  logic       head_valid;

  // the byte in the input register moves on once the queue has room
  // for every result it makes
  assign advance      = valid_q && q_stat.push_ready;
  assign byte_i.ready = !valid_q || advance;
  assign in_accept    = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_accept) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= byte_i.data_byte;
      eot_q  <= byte_i.end_of_text;
    end
  end

  // decode: state is updated only when the byte leaves the input register
  usd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .advance_i     (advance),
    .dec_o         (dec)
  );

  // result queue, also the output register
  usd_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (valid_q),
    .dec_i        (dec),
    .pop_ready_i  (result_o.ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .stat_o       (q_stat)
  );

  assign result_o.valid      = head_valid;
  assign result_o.code_point = head.code_point;
  assign result_o.kind       = head.kind;
  assign result_o.last       = head.last;

  // at most two results per byte
  `USD_ASSERT_SAME(a_two_results_max, advance, dec.n != 2'd3, "more than two results per byte")
  // a result that is not last always has its partner queued behind it
  `USD_ASSERT_SAME(a_partner_queued, head_valid && !head.last, q_stat.occ == 2'd2,
                   "first of two results without its partner")
  // end of text returns the decoder to its reset state
  `USD_ASSERT_NEXT(a_eot_clears, advance && eot_q, dec.idle, "state left after end of text")

endmodule

// File: verif/testbench.sv
// self-checking bench for utf8_stream_decoder_top: directed bytes, then random utf-8 text
// depends on usd_pkg, usd_if and the decoder rtl
module testbench import usd_pkg::*;;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 120;
  localparam int PHASE_ITEMS    = 230;
  localparam int DRAIN_CYCLES   = 20;

  localparam result_t R_NONE = '{code_point: '0, kind: KIND_CHAR, last: 1'b0};

  // one directed byte; fixed rows carry their results typed in
  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       fixed;
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // both ends of the single-byte range
    '{8'h00, 1'b0, 1'b1, 2'd1, '{21'h00000, KIND_CHAR, 1'b1}, R_NONE},
    '{8'h7f, 1'b0, 1'b1, 2'd1, '{21'h0007f, KIND_CHAR, 1'b1}, R_NONE},
    // top byte never leads; the stray continuation after it is dropped
    '{8'hff, 1'b0, 1'b1, 2'd1, '{21'h0, KIND_BAD_LEAD, 1'b1}, R_NONE},
    '{8'h80, 1'b0, 1'b1, 2'd0, R_NONE, R_NONE},
    '{8'h41, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    // smallest two-byte char, then its overlong form and a skipped byte
    '{8'hc2, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h80, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'hc0, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h80, 1'b0, 1'b1, 2'd1, '{21'h0, KIND_OVERLONG, 1'b1}, R_NONE},
    '{8'hbf, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    // three-byte overlong
    '{8'he0, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h80, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h80, 1'b0, 1'b1, 2'd1, '{21'h0, KIND_OVERLONG, 1'b1}, R_NONE},
    // largest value four bytes can carry
    '{8'hf7, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'hbf, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'hbf, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'hbf, 1'b0, 1'b1, 2'd1, '{21'h1fffff, KIND_CHAR, 1'b1}, R_NONE},
    // missing continuation; the ascii byte is still decoded
    '{8'he2, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h41, 1'b0, 1'b1, 2'd2, '{21'h0, KIND_MISSING_CONT, 1'b0},
                               '{21'h00041, KIND_CHAR, 1'b1}},
    // sequence cut off at end of text
    '{8'hc3, 1'b1, 1'b1, 2'd1, '{21'h0, KIND_TRUNCATED, 1'b1}, R_NONE},
    // missing continuation followed by a bad lead
    '{8'hc2, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'hf8, 1'b0, 1'b1, 2'd2, '{21'h0, KIND_MISSING_CONT, 1'b0},
                               '{21'h0, KIND_BAD_LEAD, 1'b1}},
    // skipped byte at end of text gives nothing
    '{8'h80, 1'b1, 1'b1, 2'd0, R_NONE, R_NONE},
    // surrogate half passes as a plain char
    '{8'hed, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'ha0, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
    '{8'h80, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  usd_byte_if   byte_if ();
  usd_result_if res_if ();

  utf8_stream_decoder_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .result_o(res_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // decoder state as the bench expects it
  logic [CP_W-1:0] pred_acc;
  logic [1:0]      pred_pending;
  logic [2:0]      pred_len;
  logic            pred_skip;

  result_t decoded_q [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  logic    hold_go = 1'b0;
  logic    hold_done = 1'b0;

  // what the item on the input port stands for, set with the item
  logic       row_fixed;
  logic [1:0] row_count;
  result_t    row_res0, row_res1;

  // advances the expected decoder state by one byte and returns its results
  task automatic utf8_predict(input logic [7:0] b, input logic eot, output int cnt,
                              output result_t first, output result_t second);
    result_t         res [2];
    logic            is_cont;
    logic            as_lead;
    logic [CP_W-1:0] floor_val;
    cnt      = 0;
    res[0]   = R_NONE;
    res[1]   = R_NONE;
    is_cont  = (b[7:6] == 2'b10);
    as_lead  = 1'b0;
    if (pred_pending != 2'd0) begin
      if (is_cont) begin
        pred_acc     = {pred_acc[CP_W-7:0], b[5:0]};
        pred_pending = pred_pending - 2'd1;
        if (pred_pending == 2'd0) begin
          case (pred_len)
            3'd2:    floor_val = MIN_LEN2;
            3'd3:    floor_val = MIN_LEN3;
            3'd4:    floor_val = MIN_LEN4;
            default: floor_val = '0;
          endcase
          if (pred_acc < floor_val) begin
            res[cnt]  = '{'0, KIND_OVERLONG, 1'b0};
            pred_skip = 1'b1;
          end else begin
            res[cnt] = '{pred_acc, KIND_CHAR, 1'b0};
          end
          cnt++;
          pred_acc = '0;
          pred_len = 3'd0;
        end
      end else begin
        // open sequence dropped, byte decoded afresh
        res[cnt]     = '{'0, KIND_MISSING_CONT, 1'b0};
        cnt++;
        pred_acc     = '0;
        pred_pending = 2'd0;
        pred_len     = 3'd0;
        as_lead      = 1'b1;
      end
    end else if (!(pred_skip && is_cont)) begin
      as_lead = 1'b1;
    end
    if (as_lead) begin
      pred_skip = 1'b0;
      casez (b)
        8'b0???????: begin
          res[cnt] = '{{13'd0, b}, KIND_CHAR, 1'b0};
          cnt++;
        end
        8'b110?????: begin
          pred_acc = {16'd0, b[4:0]}; pred_pending = 2'd1; pred_len = 3'd2;
        end
        8'b1110????: begin
          pred_acc = {17'd0, b[3:0]}; pred_pending = 2'd2; pred_len = 3'd3;
        end
        8'b11110???: begin
          pred_acc = {18'd0, b[2:0]}; pred_pending = 2'd3; pred_len = 3'd4;
        end
        default: begin
          res[cnt]  = '{'0, KIND_BAD_LEAD, 1'b0};
          cnt++;
          pred_skip = 1'b1;
        end
      endcase
    end
    if (eot) begin
      if (pred_pending != 2'd0) begin
        res[cnt] = '{'0, KIND_TRUNCATED, 1'b0};
        cnt++;
      end
      pred_acc     = '0;
      pred_pending = 2'd0;
      pred_len     = 3'd0;
      pred_skip    = 1'b0;
    end
    if (cnt > 0) res[cnt-1].last = 1'b1;
    first  = res[0];
    second = res[1];
  endtask

  // prediction on every accepted byte, checking on every accepted result
  always @(posedge clk_i) begin : scoreboard
    int      cnt;
    result_t p0, p1, want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        utf8_predict(byte_if.data_byte, byte_if.end_of_text, cnt, p0, p1);
        if (row_fixed) begin
          cnt = int'(row_count);
          p0  = row_res0;
          p1  = row_res1;
        end
        if (cnt > 0) decoded_q.push_back(p0);
        if (cnt > 1) decoded_q.push_back(p1);
      end
      if (res_if.valid && res_if.ready) begin
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          $error("unexpected result: code_point %h kind %0d last %0d",
                 res_if.code_point, res_if.kind, res_if.last);
        end else begin
          want = decoded_q.pop_front();
          if (res_if.code_point !== want.code_point) begin
            mismatch_count++;
            $error("code_point mismatch: expected %h, got %h",
                   want.code_point, res_if.code_point);
          end
          if (res_if.kind !== want.kind) begin
            mismatch_count++;
            $error("kind mismatch: expected %0d, got %0d", want.kind, res_if.kind);
          end
          if (res_if.last !== want.last) begin
            mismatch_count++;
            $error("last mismatch: expected %0d, got %0d", want.last, res_if.last);
          end
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      res_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // offers one item from a falling edge and returns at the falling edge after it is taken
  task automatic offer_byte(input logic [7:0] b, input logic eot, input logic fixed,
                            input logic [1:0] cnt, input result_t r0, input result_t r1);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid       = 1'b1;
    byte_if.data_byte   = b;
    byte_if.end_of_text = eot;
    row_fixed = fixed;
    row_count = cnt;
    row_res0  = r0;
    row_res1  = r1;
    do @(posedge clk_i); while (!byte_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // mostly well-formed sequences with random content; some overlong, cut off, stray or noise
  task automatic send_random_sequence();
    logic [7:0]      enc [4];
    logic [CP_W-1:0] v;
    int              pick, len, nsend, lo, hi;
    logic            cut_eot, eot;
    pick    = $urandom_range(99);
    len     = $urandom_range(4, 1);
    cut_eot = 1'b0;
    if (pick >= 70 && pick < 86 && len == 1) len = $urandom_range(4, 2);
    case (len)
      1:       begin lo = 0;        hi = 'h7f;     end
      2:       begin lo = 'h80;     hi = 'h7ff;    end
      3:       begin lo = 'h800;    hi = 'hffff;   end
      default: begin lo = 'h10000;  hi = 'h1fffff; end
    endcase
    if (pick >= 70 && pick < 78) begin
      hi = lo - 1;
      lo = 0;
    end
    v = CP_W'($urandom_range(hi, lo));
    case (len)
      1: enc[0] = {1'b0, v[6:0]};
      2: begin
        enc[0] = {3'b110, v[10:6]};
        enc[1] = {2'b10, v[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, v[15:12]};
        enc[1] = {2'b10, v[11:6]};
        enc[2] = {2'b10, v[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, v[20:18]};
        enc[1] = {2'b10, v[17:12]};
        enc[2] = {2'b10, v[11:6]};
        enc[3] = {2'b10, v[5:0]};
      end
    endcase
    nsend = len;
    if (pick >= 78 && pick < 86) begin
      // cut short: next byte misses a continuation, or end of text truncates
      nsend   = $urandom_range(len - 1, 1);
      cut_eot = 1'($urandom_range(1));
    end else if (pick >= 86 && pick < 93) begin
      nsend = $urandom_range(3, 1);
      for (int i = 0; i < nsend; i++) enc[i] = {2'b10, 6'($urandom_range(63))};
    end else if (pick >= 93) begin
      nsend  = 1;
      enc[0] = $urandom_range(1) ? 8'($urandom_range(255, 248)) : 8'($urandom_range(255));
    end
    for (int i = 0; i < nsend; i++) begin
      eot = (cut_eot && i == nsend - 1) || ($urandom_range(99) < 2);
      offer_byte(enc[i], eot, 1'b0, 2'd0, R_NONE, R_NONE);
    end
  endtask

  initial begin
    int target;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = 8'h00;
    byte_if.end_of_text = 1'b0;
    row_fixed    = 1'b0;
    row_count    = 2'd0;
    row_res0     = R_NONE;
    row_res1     = R_NONE;
    pred_acc     = '0;
    pred_pending = 2'd0;
    pred_len     = 3'd0;
    pred_skip    = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      offer_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].eot, DIRECTED_ROWS[i].fixed,
                 DIRECTED_ROWS[i].cnt, DIRECTED_ROWS[i].r0, DIRECTED_ROWS[i].r1);

    // random text in phases of sender and receiver idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  hold_go = 1'b1; end
        1:       begin send_idle_pct = 71; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 6;  stall_pct = 6;  end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_sequence();
    end
    byte_if.valid = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
